>>> rtl/core/uclr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package uclr_pkg;

  // ring and line buffer geometry
  localparam int unsigned FIFO_DEPTH = 64;
  localparam int unsigned LINE_DEPTH = 64;
  localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);
  // a line never holds more than 62 characters, so the line memory stops at 64
  localparam int unsigned LINE_TOP   = (LINE_DEPTH < 64) ? LINE_DEPTH : 64;
  localparam int unsigned LINE_AW    = $clog2(LINE_TOP);

  // field and port widths
  localparam int unsigned DATA_W  = 8;
  localparam int unsigned LEN_W   = 6;
  localparam int unsigned CFG_W   = 7;
  localparam int unsigned PADDR_W = 3;
  localparam int unsigned PDATA_W = 32;

  // register map (word index)
  localparam logic [PADDR_W-3:0] REG_MAX_LEN = '0;
  localparam logic [CFG_W-1:0]   MAX_LEN_RST = 7'd64;

  // character codes
  localparam logic [DATA_W-1:0] CHAR_CR  = 8'h0D;
  localparam logic [DATA_W-1:0] CHAR_LF  = 8'h0A;
  localparam logic [DATA_W-1:0] CHAR_LA  = 8'h61;
  localparam logic [DATA_W-1:0] CHAR_LZ  = 8'h7A;
  localparam logic [DATA_W-1:0] CASE_OFS = 8'd32;

  // ring index advance with wrap
  function automatic logic [FIFO_AW-1:0] fifo_next(input logic [FIFO_AW-1:0] idx);
    logic [FIFO_AW-1:0] nxt;
    if (idx == FIFO_AW'(FIFO_DEPTH - 1)) begin
      nxt = '0;
    end else begin
      nxt = idx + 1'b1;
    end
    return nxt;
  endfunction

  // fold a to z onto upper case
  function automatic logic [DATA_W-1:0] to_upper(input logic [DATA_W-1:0] ch);
    logic [DATA_W-1:0] res;
    if (ch >= CHAR_LA && ch <= CHAR_LZ) begin
      res = ch - CASE_OFS;
    end else begin
      res = ch;
    end
    return res;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/uclr_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module uclr_ram #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned WIDTH = 8,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> rtl/core/uart_command_line_receiver_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Receive ring plus command-line framer. A push (action 0) returns one result in
// the next cycle, with dropped set when the ring already held FIFO_DEPTH-1
// bytes. A poll (action 1) keeps busy high while it consumes ring bytes (the ring
// memory has a single read port, read once per cycle) and, when a line completes,
// while it emits the characters (one line memory read per cycle); results come
// in the cycle after the reads, one per cycle. Results are shown for exactly one
// cycle on result_valid_o and cannot be held off by the receiver. The memories
// start undefined and need no clearing pass after reset. max_len may only be
// written while the block is idle.
module uart_command_line_receiver_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // command channel
  input  logic                          start,
  output logic                          busy,
  input  logic                          action_i,
  input  logic [uclr_pkg::DATA_W-1:0]   rx_byte_i,
  // result channel
  output logic                          result_valid_o,
  output logic [uclr_pkg::DATA_W-1:0]   cmd_char_o,
  output logic [uclr_pkg::LEN_W-1:0]    cmd_length_o,
  output logic                          has_command_o,
  output logic                          last_o,
  output logic                          dropped_o,
  // configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [uclr_pkg::PADDR_W-1:0]  paddr,
  input  logic [uclr_pkg::PDATA_W-1:0]  pwdata,
  output logic [uclr_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready
);

  import uclr_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_PROC = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  localparam logic [CFG_W-1:0] LINE_TOP_W = CFG_W'(LINE_TOP);
  localparam logic [CFG_W-1:0] LIM_MIN    = 7'd2;

  logic [1:0]         state_q, state_d;
  logic [FIFO_AW-1:0] wr_q, wr_d;
  logic [FIFO_AW-1:0] rd_q, rd_d;
  logic [LINE_AW-1:0] cnt_q, cnt_d;
  logic [LINE_AW-1:0] k_q, k_d;
  logic [CFG_W-1:0]   max_len_q, max_len_d;

  logic               res_vld_q, res_vld_d;
  logic [LEN_W-1:0]   res_len_q, res_len_d;
  logic               res_has_q, res_has_d;
  logic               res_last_q, res_last_d;
  logic               res_drop_q, res_drop_d;

  logic               fifo_we, fifo_re;
  logic [FIFO_AW-1:0] fifo_raddr;
  logic [DATA_W-1:0]  fifo_rdata;
  logic               line_we, line_re;
  logic [DATA_W-1:0]  line_rdata;
  logic [DATA_W-1:0]  line_wdata;

  logic [CFG_W-1:0]   lim_sat;
  logic [LINE_AW-1:0] lim_m1;
  logic [LINE_AW-1:0] cnt_inc;
  logic [LINE_AW-1:0] k_inc;
  logic [FIFO_AW-1:0] wr_nxt;
  logic [FIFO_AW-1:0] rd_nxt;
  logic               is_term;
  logic               go_on;
  logic               none_res;
  logic               emit_last;
  logic               cfg_wr;
  logic               cfg_hit;

  // memories
  uclr_ram #(
    .DEPTH(FIFO_DEPTH),
    .WIDTH(DATA_W)
  ) u_fifo_ram (
    .clk_i  (clk_i),
    .we_i   (fifo_we),
    .waddr_i(wr_q),
    .wdata_i(rx_byte_i),
    .re_i   (fifo_re),
    .raddr_i(fifo_raddr),
    .rdata_o(fifo_rdata)
  );

  uclr_ram #(
    .DEPTH(LINE_TOP),
    .WIDTH(DATA_W)
  ) u_line_ram (
    .clk_i  (clk_i),
    .we_i   (line_we),
    .waddr_i(cnt_q),
    .wdata_i(line_wdata),
    .re_i   (line_re),
    .raddr_i(k_q),
    .rdata_o(line_rdata)
  );

  // configuration access
  assign cfg_hit = (paddr[PADDR_W-1:2] == REG_MAX_LEN);
  assign cfg_wr  = psel && penable && pwrite && cfg_hit;
  assign pready  = 1'b1;
  assign prdata  = cfg_hit ? PDATA_W'(max_len_q) : '0;

  always_comb begin
    max_len_d = max_len_q;
    if (cfg_wr) begin
      max_len_d = pwdata[CFG_W-1:0];
    end
  end

  // effective line limit
  always_comb begin
    if (max_len_q < LIM_MIN) begin
      lim_sat = LIM_MIN;
    end else if (max_len_q > LINE_TOP_W) begin
      lim_sat = LINE_TOP_W;
    end else begin
      lim_sat = max_len_q;
    end
  end

  assign lim_m1     = LINE_AW'(lim_sat - 7'd1);
  assign cnt_inc    = cnt_q + 1'b1;
  assign k_inc      = k_q + 1'b1;
  assign wr_nxt     = fifo_next(wr_q);
  assign rd_nxt     = fifo_next(rd_q);
  assign fifo_raddr = rd_q;
  assign line_wdata = to_upper(fifo_rdata);
  assign is_term    = (fifo_rdata == CHAR_CR) || (fifo_rdata == CHAR_LF);
  assign emit_last  = (k_inc == cnt_q);

  // sequencer
  always_comb begin
    state_d    = state_q;
    wr_d       = wr_q;
    rd_d       = rd_q;
    cnt_d      = cnt_q;
    k_d        = k_q;
    res_vld_d  = 1'b0;
    res_len_d  = res_len_q;
    res_has_d  = res_has_q;
    res_last_d = res_last_q;
    res_drop_d = res_drop_q;
    fifo_we    = 1'b0;
    fifo_re    = 1'b0;
    line_we    = 1'b0;
    line_re    = 1'b0;
    go_on      = 1'b0;
    none_res   = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (start) begin
          if (!action_i) begin
            // push transaction
            fifo_we    = (wr_nxt != rd_q);
            if (wr_nxt != rd_q) begin
              wr_d = wr_nxt;
            end
            res_vld_d  = 1'b1;
            res_len_d  = '0;
            res_has_d  = 1'b0;
            res_last_d = 1'b1;
            res_drop_d = (wr_nxt == rd_q);
          end else if (cnt_q >= lim_m1) begin
            // limit lowered under a held line
            cnt_d    = '0;
            none_res = 1'b1;
          end else if (rd_q == wr_q) begin
            none_res = 1'b1;
          end else begin
            fifo_re = 1'b1;
            rd_d    = rd_nxt;
            state_d = ST_PROC;
          end
        end
      end
      ST_PROC: begin
        if (is_term) begin
          if (cnt_q != '0) begin
            k_d     = '0;
            state_d = ST_EMIT;
          end else begin
            go_on = 1'b1;
          end
        end else begin
          line_we = 1'b1;
          if (cnt_inc >= lim_m1) begin
            // overlong line is discarded
            cnt_d    = '0;
            none_res = 1'b1;
            state_d  = ST_IDLE;
          end else begin
            cnt_d = cnt_inc;
            go_on = 1'b1;
          end
        end
        if (go_on) begin
          if (rd_q == wr_q) begin
            none_res = 1'b1;
            state_d  = ST_IDLE;
          end else begin
            fifo_re = 1'b1;
            rd_d    = rd_nxt;
          end
        end
      end
      ST_EMIT: begin
        line_re    = 1'b1;
        res_vld_d  = 1'b1;
        res_len_d  = LEN_W'(cnt_q);
        res_has_d  = 1'b1;
        res_last_d = emit_last;
        res_drop_d = 1'b0;
        k_d        = k_inc;
        if (emit_last) begin
          cnt_d   = '0;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // poll that reports no command
    if (none_res) begin
      res_vld_d  = 1'b1;
      res_len_d  = '0;
      res_has_d  = 1'b0;
      res_last_d = 1'b1;
      res_drop_d = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      wr_q      <= '0;
      rd_q      <= '0;
      cnt_q     <= '0;
      k_q       <= '0;
      max_len_q <= MAX_LEN_RST;
      res_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      wr_q      <= wr_d;
      rd_q      <= rd_d;
      cnt_q     <= cnt_d;
      k_q       <= k_d;
      max_len_q <= max_len_d;
      res_vld_q <= res_vld_d;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    res_len_q  <= res_len_d;
    res_has_q  <= res_has_d;
    res_last_q <= res_last_d;
    res_drop_q <= res_drop_d;
  end

  assign busy           = (state_q != ST_IDLE);
  assign result_valid_o = res_vld_q;
  assign cmd_char_o     = res_has_q ? line_rdata : '0;
  assign cmd_length_o   = res_len_q;
  assign has_command_o  = res_has_q;
  assign last_o         = res_last_q;
  assign dropped_o      = res_drop_q;

  // a push to a full ring always comes back flagged as dropped
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && !action_i && (wr_nxt == rd_q) |=> result_valid_o && dropped_o)
    else $error("full ring did not flag a dropped byte");

  // an accepted transaction either answers next cycle or keeps busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> result_valid_o || busy)
    else $error("accepted transaction produced nothing");

  // line emission only runs with a held line
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT) |-> (cnt_q != '0) && (k_q < cnt_q))
    else $error("line emission with bad count");

  // held count stays under the limit while scanning
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_PROC) |-> (cnt_q < lim_m1))
    else $error("held line exceeds limit");

  // a final command character ends the emission
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && has_command_o && last_o |-> !busy || (state_q == ST_IDLE))
    else $error("emission continued after last character");

endmodule

`default_nettype wire
